// File: rtl/sorq_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the sorted ready queue: record layout, operation and status codes.
// No dependencies.
package sorq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // Width of one field of a record.
   localparam int FIELD_W = 16;
   // Four fields: id, arrival, service, remaining time (lowest first).
   localparam int REC_W   = 4 * FIELD_W;
   localparam int KEY_LSB = 3 * FIELD_W;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [REC_W-1:0]    record_type;

   localparam op_type OP_APPEND = 2'd0;
   localparam op_type OP_SORTED = 2'd1;
   localparam op_type OP_DEQUEUE = 2'd2;
   localparam op_type OP_UNUSED = 2'd3;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

endpackage

// File: rtl/sorted_ready_queue_core.sv
`timescale 1ns / 1ps
// Sorted ready queue: top level with the queue control sequencer around one record RAM.
// Depends on sorq_pkg and sorq_ram.
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------------
//  req_    | in  | tuser: operation; tdata: id, arrival, service, remaining time
//  rsp_    | out | tuser: record_valid, status; tdata: record fields, entry_count
//
//  Append, dropped enqueue, empty dequeue and unused code finish in the idle state;
//  dequeue does one RAM read; sorted enqueue walks back from the rear past the k
//  entries the record moves past, up to DEPTH-1 (one RAM read and one write per
//  step of the backward walk), then writes the record into its slot.
//  Reset clears head pointer, count, sequencer and output valid; the RAM is not
//  cleared, only entries below the count are ever read.
//  A new beat is taken only in the idle state with the result register free or
//  draining; a stalled result holds the sequencer in idle.
module sorted_ready_queue_core
   import sorq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // slave side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [15:0] pid, [31:16] arrival,
                                   // [47:32] service, [63:48] remaining
   input  logic [1:0]  req_tuser,  // [1:0] operation
   // master side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // [15:0] pid, [31:16] arrival,
                                   // [47:32] service, [63:48] remaining,
                                   // [68:64] entry_count, [71:69] zero
   output logic [2:0]  rsp_tuser   // [0] record_valid, [2:1] status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] count_type;

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SORT  = 2'd1;
   localparam logic [1:0] ST_PLACE = 2'd2;
   localparam logic [1:0] ST_DEQ   = 2'd3;

   localparam addr_type  LAST_ADDR = AW'(DEPTH - 1);
   localparam count_type FULL_CNT  = CW'(DEPTH);

   logic [1:0] state_ff, state_in;
   addr_type   head_ff, head_in;
   count_type  count_ff, count_in;
   addr_type   ptr_ff, ptr_in;     // slot the moving record would land in
   addr_type   prev_ff, prev_in;   // slot just ahead of ptr
   count_type  steps_ff, steps_in; // logical position of ptr from the head
   record_type rec_ff, rec_in;

   logic       rsp_valid_ff, rsp_valid_in;
   record_type rsp_rec_ff, rsp_rec_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_hit_ff, rsp_hit_in;
   count_type  rsp_count_ff, rsp_count_in;

   logic       wr_en, rd_en;
   addr_type   wr_addr, rd_addr;
   record_type wr_data, rd_data;

   logic       take;
   op_type     req_op;
   logic [AW:0] tail_sum;
   addr_type   tail;
   logic       key_greater;

   function automatic addr_type dec_addr(input addr_type a);
      return (a == '0) ? LAST_ADDR : a - 1'b1;
   endfunction

   function automatic addr_type inc_addr(input addr_type a);
      return (a == LAST_ADDR) ? '0 : a + 1'b1;
   endfunction

   sorq_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign take       = req_tvalid && req_tready;
   assign req_op     = req_tuser;

   // Rear slot: head plus count, wrapped once (count stays below DEPTH here)
   assign tail_sum = {1'b0, head_ff} + (AW + 1)'(count_ff);
   assign tail     = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                    : AW'(tail_sum);

   assign key_greater = rd_data[REC_W-1:KEY_LSB] > rec_ff[REC_W-1:KEY_LSB];

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      rec_in        = rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_rec_in    = rsp_rec_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = rec_ff;
      rd_en         = 1'b0;
      rd_addr       = prev_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               // default result: no record, status ok, count unchanged
               rsp_valid_in  = 1'b1;
               rsp_rec_in    = '0;
               rsp_hit_in    = 1'b0;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = count_ff;
               unique case (req_op) inside
                  OP_APPEND, OP_SORTED: begin
                     if (count_ff == FULL_CNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (req_op == OP_APPEND || count_ff == '0) begin
                        wr_en        = 1'b1;
                        wr_addr      = tail;
                        wr_data      = req_tdata;
                        count_in     = count_ff + 1'b1;
                        rsp_count_in = count_ff + 1'b1;
                     end else begin
                        // walk back from the rear; hold the result until placed
                        rsp_valid_in = 1'b0;
                        rec_in       = req_tdata;
                        ptr_in       = tail;
                        prev_in      = dec_addr(tail);
                        steps_in     = count_ff;
                        rd_en        = 1'b1;
                        rd_addr      = dec_addr(tail);
                        state_in     = ST_SORT;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        rd_addr      = head_ff;
                        state_in     = ST_DEQ;
                     end
                  end
                  default: begin
                     // unused code: queue unchanged
                  end
               endcase
            end
         end

         ST_SORT: begin
            if (key_greater) begin
               // shift the predecessor back one slot and advance toward the head
               wr_en    = 1'b1;
               wr_addr  = ptr_ff;
               wr_data  = rd_data;
               ptr_in   = prev_ff;
               prev_in  = dec_addr(prev_ff);
               steps_in = steps_ff - 1'b1;
               if (steps_ff == count_type'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = dec_addr(prev_ff);
               end
            end else begin
               wr_en         = 1'b1;
               wr_addr       = ptr_ff;
               wr_data       = rec_ff;
               count_in      = count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_rec_in    = '0;
               rsp_hit_in    = 1'b0;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = count_ff + 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_PLACE: begin
            // record belongs at the head
            wr_en         = 1'b1;
            wr_addr       = ptr_ff;
            wr_data       = rec_ff;
            count_in      = count_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_rec_in    = '0;
            rsp_hit_in    = 1'b0;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = count_ff + 1'b1;
            state_in      = ST_IDLE;
         end

         ST_DEQ: begin
            // head data has arrived from the RAM: drop it from the queue
            head_in       = inc_addr(head_ff);
            count_in      = count_ff - 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_rec_in    = rd_data;
            rsp_hit_in    = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = count_ff - 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      rec_ff        <= rec_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, COUNT_W'(rsp_count_ff), rsp_rec_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_hit_ff};

endmodule

// File: rtl/sorq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on sorq_pkg for the default word width and depth.
module sorq_ram
   import sorq_pkg::*;
#(
   parameter int WIDTH = REC_W,
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
